FILE: rtl/load_based_dvfs_governor_assert.svh
// Assertion macros used by the checker file.
`ifndef LOAD_BASED_DVFS_GOVERNOR_ASSERT_SVH
`define LOAD_BASED_DVFS_GOVERNOR_ASSERT_SVH
`define ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

FILE: rtl/ldg_pkg.sv
// Types, constants and functions of the load based frequency governor.
`default_nettype none
package ldg_pkg;
    localparam int NUM_CPUS = 2;
    localparam int CPU_W = (NUM_CPUS > 1) ? $clog2(NUM_CPUS) : 1;
    localparam int HIST_LEN = 10;
    localparam logic [21:0] FREQ_MAX = 22'h3FFFFF;
    localparam logic [21:0] MAX_FREQ_RESET = 22'd1200000;
    localparam logic [6:0] TARGET_LOAD_RESET = 7'd90;
    localparam logic CFG_MAX_FREQ = 1'b0;
    localparam logic CFG_TARGET_LOAD = 1'b1;
    // Reciprocals of 100: the first is exact with a shift of 19 for sums up to 43690,
    // the second with a shift of 36 for products below 2^30.
    localparam logic [12:0] DIV100_MUL_SUM = 13'd5243;
    localparam logic [29:0] DIV100_MUL_FREQ = 30'd687194768;

    typedef enum logic [1:0]
    {
        DEC_GO_MAX = 2'd0,
        DEC_STEP_UP = 2'd1,
        DEC_HOLD = 2'd2,
        DEC_LOWER = 2'd3
    } decision_t;

    typedef struct packed
    {
        logic        action;
        logic [3:0]  cpu_number;
        logic        last_cpu;
        logic [31:0] total_ticks;
        logic [31:0] idle_ticks;
        logic [21:0] current_frequency_khz;
    } in_item_t;

    typedef struct packed
    {
        logic        change_request;
        logic [21:0] target_frequency_khz;
        logic [1:0]  decision;
        logic [6:0]  peak_load;
    } out_item_t;

    typedef struct packed
    {
        logic        start;
        logic [63:0] dividend;
        logic [31:0] divisor;
    } div_req_t;

    typedef enum logic [3:0]
    {
        ST_IDLE,
        ST_READ,
        ST_LOAD,
        ST_LDIV,
        ST_PEAK,
        ST_HIST,
        ST_SCALE,
        ST_MUL,
        ST_RECIP,
        ST_TSTART,
        ST_TDIV,
        ST_DONE,
        ST_OUT
    } state_t;

    function automatic logic [4:0] weight(input logic [3:0] i);
        logic [4:0] w;
        case (i)
            4'd0: w = 5'd25;
            4'd1: w = 5'd20;
            4'd2: w = 5'd15;
            4'd3: w = 5'd10;
            default: w = 5'd5;
        endcase
        return w;
    endfunction
endpackage
`default_nettype wire

FILE: rtl/ldg_divider.sv
// Restoring divider producing one quotient bit per cycle.
`default_nettype none
module ldg_divider
(
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire ldg_pkg::div_req_t req,
    output logic                 busy,
    output logic [63:0]          quotient
);
    import ldg_pkg::*;
    logic [63:0] q_reg, q_next;
    logic [32:0] r_reg, r_next;
    logic [31:0] d_reg, d_next;
    logic [6:0]  cnt_reg, cnt_next;
    logic [32:0] trial;

    always_comb
    begin
        q_next = q_reg;
        r_next = r_reg;
        d_next = d_reg;
        cnt_next = cnt_reg;
        trial = '0;
        if (req.start)
        begin
            q_next = req.dividend;
            r_next = '0;
            d_next = req.divisor;
            cnt_next = 7'd64;
        end
        else if (cnt_reg != 7'd0)
        begin
            trial = {r_reg[31:0], q_reg[63]};
            if (trial >= {1'b0, d_reg})
            begin
                r_next = trial - {1'b0, d_reg};
                q_next = {q_reg[62:0], 1'b1};
            end
            else
            begin
                r_next = trial;
                q_next = {q_reg[62:0], 1'b0};
            end
            cnt_next = cnt_reg - 7'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg <= q_next;
        r_reg <= r_next;
        d_reg <= d_next;
    end

    assign busy = (cnt_reg != 7'd0) || req.start;
    assign quotient = q_reg;
endmodule
`default_nettype wire

FILE: rtl/load_based_dvfs_governor.sv
// Top level of the load based frequency governor.
// Channel  Direction  Handshake                 Payload
// in       input      in_valid / in_ready       ldg_pkg::in_item_t
// out      output     out_valid / out_ready     ldg_pkg::out_item_t
// cfg      input      cfg_valid / cfg_ready     cfg_index, cfg_data
// One request at a time. A baseline request passes only the read and load states, a sample
// waits on the 64-step shared divider when its load needs it, and a lowering decision also
// waits on the ten-entry history sum and a second division by the target load.
// Counters live in a synchronous memory read and written back per item.
// The counter and history entries have valid bits cleared by reset; no clearing pass.
// A waiting result blocks the next request until out_ready is high.
`default_nettype none
module load_based_dvfs_governor
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    output logic                      in_ready,
    input  wire ldg_pkg::in_item_t    in_data,
    output logic                      out_valid,
    input  wire logic                 out_ready,
    output ldg_pkg::out_item_t        out_data,
    input  wire logic                 cfg_valid,
    output logic                      cfg_ready,
    input  wire logic                 cfg_index,
    input  wire logic [31:0]          cfg_data
);
    import ldg_pkg::*;

    state_t state_reg, state_next;
    in_item_t item_reg;
    logic [63:0] mem [NUM_CPUS];
    logic [NUM_CPUS-1:0] mv_reg;
    logic        rd_ok_reg;
    logic [63:0] rd_reg;
    logic [21:0] maxf_reg;
    logic [6:0]  tl_reg;
    logic [6:0]  hist_reg [HIST_LEN];
    logic [HIST_LEN-1:0] hv_reg;
    logic [3:0]  pos_reg;
    logic [6:0]  peak_reg, peak_next;
    logic [6:0]  ld_reg;
    logic [31:0] delta_total, delta_idle;
    logic [3:0]  hi_reg;
    logic [13:0] sum_reg;
    logic [6:0]  scale_reg;
    logic [28:0] prod_reg;
    logic [21:0] fq_reg;
    logic [26:0] scale_prod;
    logic [58:0] recip_prod;
    out_item_t   res_reg, res_next;
    logic        cpu_ok;
    div_req_t    dreq;
    logic        dbusy;
    logic [63:0] dq;
    logic [6:0]  up_max, up, down;
    logic [6:0]  tl_eff;
    logic [3:0]  hidx;
    logic [6:0]  hval;
    logic [22:0] stepped;

    ldg_divider u_div (.clk(clk), .rst_n(rst_n), .req(dreq), .busy(dbusy), .quotient(dq));

    assign cpu_ok = ({28'd0, item_reg.cpu_number} < NUM_CPUS);
    assign in_ready = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign out_valid = (state_reg == ST_OUT);
    assign out_data = res_reg;
    assign tl_eff = (tl_reg == 7'd0) ? 7'd1 : tl_reg;
    assign hidx = (pos_reg >= hi_reg) ? pos_reg - hi_reg : pos_reg + 4'd10 - hi_reg;
    assign hval = hv_reg[hidx] ? hist_reg[hidx] : 7'd0;
    assign stepped = {1'b0, item_reg.current_frequency_khz} + 23'd1000;
    assign scale_prod = {13'd0, sum_reg} * {14'd0, DIV100_MUL_SUM};
    assign recip_prod = {30'd0, prod_reg} * {29'd0, DIV100_MUL_FREQ};

    always_comb
    begin
        if (item_reg.current_frequency_khz < 22'd400000)
        begin
            up_max = 7'd95; up = 7'd60; down = 7'd30;
        end
        else if (item_reg.current_frequency_khz < 22'd600000)
        begin
            up_max = 7'd95; up = 7'd70; down = 7'd40;
        end
        else
        begin
            up_max = 7'd90; up = 7'd80; down = 7'd50;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        dreq = '0;
        res_next = res_reg;
        peak_next = peak_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_READ;
                end
            end
            ST_READ:
            begin
                state_next = ST_LOAD;
            end
            ST_LOAD:
            begin
                if (!item_reg.action)
                begin
                    state_next = ST_IDLE;
                end
                else if (cpu_ok && delta_total != 32'd0 && delta_total > delta_idle)
                begin
                    dreq.start = 1'b1;
                    dreq.dividend = 64'd100 * {32'd0, delta_total - delta_idle};
                    dreq.divisor = delta_total;
                    state_next = ST_LDIV;
                end
                else
                begin
                    state_next = ST_PEAK;
                end
            end
            ST_LDIV:
            begin
                if (!dbusy)
                begin
                    state_next = ST_PEAK;
                end
            end
            ST_PEAK:
            begin
                if (!item_reg.last_cpu)
                begin
                    if (ld_reg > peak_reg)
                    begin
                        peak_next = ld_reg;
                    end
                    state_next = ST_IDLE;
                end
                else
                begin
                    peak_next = '0;
                    res_next.peak_load = (ld_reg > peak_reg) ? ld_reg : peak_reg;
                    state_next = ST_HIST;
                end
            end
            ST_HIST:
            begin
                if (res_reg.peak_load > up_max)
                begin
                    res_next.target_frequency_khz = maxf_reg;
                    res_next.change_request = 1'b1;
                    res_next.decision = DEC_GO_MAX;
                    state_next = ST_OUT;
                end
                else if (res_reg.peak_load > up)
                begin
                    res_next.target_frequency_khz = stepped[22] ? FREQ_MAX : stepped[21:0];
                    res_next.change_request = 1'b1;
                    res_next.decision = DEC_STEP_UP;
                    state_next = ST_OUT;
                end
                else if (res_reg.peak_load >= down)
                begin
                    res_next.target_frequency_khz = item_reg.current_frequency_khz;
                    res_next.change_request = 1'b0;
                    res_next.decision = DEC_HOLD;
                    state_next = ST_OUT;
                end
                else if (hi_reg == 4'd9)
                begin
                    state_next = ST_SCALE;
                end
            end
            ST_SCALE:
            begin
                state_next = ST_MUL;
            end
            ST_MUL:
            begin
                state_next = ST_RECIP;
            end
            ST_RECIP:
            begin
                state_next = ST_TSTART;
            end
            ST_TSTART:
            begin
                dreq.start = 1'b1;
                dreq.dividend = {42'd0, fq_reg} * 64'd100;
                dreq.divisor = {25'd0, tl_eff};
                state_next = ST_TDIV;
            end
            ST_TDIV:
            begin
                if (!dbusy)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                res_next.target_frequency_khz = (dq > {42'd0, FREQ_MAX}) ? FREQ_MAX : dq[21:0];
                res_next.change_request = 1'b1;
                res_next.decision = DEC_LOWER;
                state_next = ST_OUT;
            end
            ST_OUT:
            begin
                if (out_ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            maxf_reg <= MAX_FREQ_RESET;
            tl_reg <= TARGET_LOAD_RESET;
            hv_reg <= '0;
            mv_reg <= '0;
            pos_reg <= '0;
            peak_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            peak_reg <= peak_next;
            if (cfg_valid)
            begin
                if (cfg_index == CFG_MAX_FREQ)
                begin
                    maxf_reg <= cfg_data[21:0];
                end
                else
                begin
                    tl_reg <= cfg_data[6:0];
                end
            end
            if (state_reg == ST_READ && cpu_ok)
            begin
                mv_reg[item_reg.cpu_number[CPU_W-1:0]] <= 1'b1;
            end
            if (state_reg == ST_PEAK && item_reg.last_cpu)
            begin
                hv_reg[pos_reg] <= 1'b1;
            end
            if (state_reg == ST_HIST && state_next == ST_OUT)
            begin
                pos_reg <= (pos_reg == 4'd9) ? 4'd0 : pos_reg + 4'd1;
            end
            if (state_reg == ST_DONE)
            begin
                pos_reg <= (pos_reg == 4'd9) ? 4'd0 : pos_reg + 4'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
        if (state_reg == ST_IDLE && in_valid)
        begin
            item_reg <= in_data;
        end
        if (state_reg == ST_READ)
        begin
            rd_reg <= mem[item_reg.cpu_number[CPU_W-1:0]];
            rd_ok_reg <= mv_reg[item_reg.cpu_number[CPU_W-1:0]];
            if (cpu_ok)
            begin
                mem[item_reg.cpu_number[CPU_W-1:0]] <=
                    {item_reg.total_ticks, item_reg.idle_ticks};
            end
        end
        if (state_reg == ST_LOAD)
        begin
            ld_reg <= '0;
        end
        if (state_reg == ST_LDIV && !dbusy)
        begin
            ld_reg <= dq[6:0];
        end
        if (state_reg == ST_PEAK && item_reg.last_cpu)
        begin
            hist_reg[pos_reg] <= (ld_reg > peak_reg) ? ld_reg : peak_reg;
            hi_reg <= '0;
            sum_reg <= '0;
        end
        if (state_reg == ST_HIST)
        begin
            hi_reg <= hi_reg + 4'd1;
            sum_reg <= sum_reg + 14'(hval * weight(hi_reg));
        end
        if (state_reg == ST_SCALE)
        begin
            scale_reg <= scale_prod[25:19];
        end
        if (state_reg == ST_MUL)
        begin
            prod_reg <= {7'd0, item_reg.current_frequency_khz} * {22'd0, scale_reg};
        end
        if (state_reg == ST_RECIP)
        begin
            fq_reg <= recip_prod[57:36];
        end
    end

    always_comb
    begin
        delta_total = item_reg.total_ticks -
            ((cpu_ok && rd_ok_reg) ? rd_reg[63:32] : 32'd0);
        delta_idle = item_reg.idle_ticks -
            ((cpu_ok && rd_ok_reg) ? rd_reg[31:0] : 32'd0);
    end
endmodule
`default_nettype wire

FILE: rtl/ldg_checker.sv
// Port-level checker for the load based frequency governor, with its bind.
`default_nettype none
`include "load_based_dvfs_governor_assert.svh"
module ldg_checker
(
    input wire logic               clk,
    input wire logic               rst_n,
    input wire logic               in_valid,
    input wire logic               in_ready,
    input wire logic               out_valid,
    input wire logic               out_ready,
    input wire ldg_pkg::out_item_t out_data
);
    import ldg_pkg::*;
    `ASSERT_IMPL(a_one_at_a_time, out_valid, !in_ready)
    `ASSERT_IMPL(a_peak_range, out_valid, out_data.peak_load <= 7'd100)
    `ASSERT_IMPL(a_hold_no_change, out_valid && out_data.decision == DEC_HOLD,
        !out_data.change_request)
    `ASSERT_NEXT(a_out_stays, out_valid && !out_ready, out_valid && $stable(out_data))
endmodule

bind load_based_dvfs_governor ldg_checker u_ldg_checker
(
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
);
`default_nettype wire
